// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define IRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define IRC_ASSERT_NEVER(lbl, cond, msg) \
  `IRC_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/irc_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 receive classifier package
// Types and constants shared by the classifier front end, queue and back end.
// ----------------------------------------------------------------------------
package irc_pkg;

  typedef enum logic [3:0] {
    VERDICT_ICMP      = 4'd0,
    VERDICT_UDP       = 4'd1,
    VERDICT_TCP       = 4'd2,
    VERDICT_SHORT     = 4'd3,
    VERDICT_VERSION   = 4'd4,
    VERDICT_HEADER    = 4'd5,
    VERDICT_CHECKSUM  = 4'd6,
    VERDICT_POLICY    = 4'd7,
    VERDICT_TRUNCATED = 4'd8,
    VERDICT_NOTOURS   = 4'd9,
    VERDICT_PROTOCOL  = 4'd10
  } irc_verdict_e;

  typedef enum logic [1:0] {
    CFG_OWN_FIRST  = 2'd0,
    CFG_OWN_SECOND = 2'd1,
    CFG_OFFERED    = 2'd2
  } irc_cfg_index_e;

  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [31:0] ADDR_BROADCAST = 32'hFFFF_FFFF;
  localparam logic [31:0] ADDR_LOOPBACK  = 32'h7F00_0001;
  localparam logic [31:0] ADDR_ANY       = 32'h0000_0000;
  localparam logic [15:0] PORT_BOOTPS    = 16'd67;
  localparam logic [15:0] PORT_BOOTPC    = 16'd68;
  localparam logic [15:0] PORT_DNS       = 16'd53;
  localparam logic [15:0] PORT_HTTP      = 16'd80;
  localparam logic [15:0] PORT_SSH       = 16'd22;
  localparam logic [15:0] SUM_ALL_ONES   = 16'hFFFF;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [15:0] HDR_MIN_BYTES  = 16'd20;
  localparam logic [16:0] UDP_HDR_BYTES  = 17'd8;
  localparam logic [16:0] TCP_HDR_BYTES  = 17'd20;

  // Byte offsets of captured header words.
  localparam logic [15:0] OFF_VER_LEN = 16'd0;
  localparam logic [15:0] OFF_TOTAL   = 16'd2;
  localparam logic [15:0] OFF_TTL     = 16'd8;
  localparam logic [15:0] OFF_SRC_HI  = 16'd12;
  localparam logic [15:0] OFF_SRC_LO  = 16'd14;
  localparam logic [15:0] OFF_DST_HI  = 16'd16;
  localparam logic [15:0] OFF_DST_LO  = 16'd18;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Everything the back end needs to judge one finished packet.
  typedef struct packed {
    logic [15:0] len;
    logic [7:0]  ver_len;
    logic [15:0] hdr_sum;
    logic [15:0] total_len;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] port;
    logic        auth;
  } irc_summary_t;

  typedef struct packed {
    logic [31:0] own_first;
    logic [31:0] own_second;
    logic [31:0] offered;
  } irc_cfg_t;

  typedef struct packed {
    logic push;
    logic full;
  } irc_qctl_t;

endpackage

// File: rtl/irc_front.sv
// ----------------------------------------------------------------------------
// IPv4 receive classifier front end
// Captures header fields word by word, keeps the header sum and hands a
// packet summary to the queue on the last word.
// ----------------------------------------------------------------------------
module irc_front import irc_pkg::*; #(
  parameter int unsigned MaxPacketBytes = 65535
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_stall_i,
  input  logic [15:0]  packet_word_i,
  input  logic         last_word_i,
  input  logic         odd_tail_i,
  input  logic         source_authenticated_i,
  output logic         push_o,
  output irc_summary_t summary_o
);

  localparam logic [15:0] MaxBytes = 16'(MaxPacketBytes);

  logic [15:0] count_q, count_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  vl_q, vl_d;
  logic [15:0] total_q, total_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] port_q, port_d;

  logic        accept;
  logic        odd;
  logic [15:0] word;
  logic [5:0]  hl;
  logic [6:0]  port_off;
  logic [16:0] sum_wide;
  logic [16:0] next_count;

  always_comb begin
    accept     = in_valid_i && !in_stall_i;
    odd        = last_word_i && odd_tail_i;
    word       = odd ? {packet_word_i[15:8], 8'h00} : packet_word_i;
    count_d    = count_q;
    sum_d      = sum_q;
    vl_d       = vl_q;
    total_d    = total_q;
    ttl_d      = ttl_q;
    proto_d    = proto_q;
    src_d      = src_q;
    dst_d      = dst_q;
    port_d     = port_q;
    hl         = '0;
    port_off   = '0;
    sum_wide   = '0;
    next_count = '0;
    if (accept && (count_q < MaxBytes)) begin
      if (count_q == OFF_VER_LEN) begin
        vl_d = word[15:8];
      end
      hl       = {vl_d[3:0], 2'b00};
      port_off = {1'b0, hl} + 7'd2;
      if (count_q < {10'b0, hl}) begin
        sum_wide = {1'b0, sum_q} + {1'b0, word};
        sum_d    = sum_wide[15:0] + {15'b0, sum_wide[16]};
      end
      if (count_q == OFF_TOTAL) total_d = word;
      if (count_q == OFF_TTL) begin
        ttl_d   = word[15:8];
        proto_d = word[7:0];
      end
      if (count_q == OFF_SRC_HI) src_d[31:16] = word;
      if (count_q == OFF_SRC_LO) src_d[15:0]  = word;
      if (count_q == OFF_DST_HI) dst_d[31:16] = word;
      if (count_q == OFF_DST_LO) dst_d[15:0]  = word;
      if (count_q == {9'b0, port_off}) port_d = word;
      next_count = {1'b0, count_q} + (odd ? 17'd1 : 17'd2);
      count_d    = (next_count > {1'b0, MaxBytes}) ? MaxBytes : next_count[15:0];
    end
  end

  assign push_o = accept && last_word_i;

  always_comb begin
    summary_o.len       = count_d;
    summary_o.ver_len   = vl_d;
    summary_o.hdr_sum   = sum_d;
    summary_o.total_len = total_d;
    summary_o.ttl       = ttl_d;
    summary_o.proto     = proto_d;
    summary_o.src       = src_d;
    summary_o.dst       = dst_d;
    summary_o.port      = port_d;
    summary_o.auth      = source_authenticated_i;
  end

  // Per-packet state starts over after every last word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      vl_q    <= '0;
      total_q <= '0;
      ttl_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      port_q  <= '0;
    end else if (push_o) begin
      count_q <= '0;
      sum_q   <= '0;
      vl_q    <= '0;
      total_q <= '0;
      ttl_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      port_q  <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      vl_q    <= vl_d;
      total_q <= total_d;
      ttl_q   <= ttl_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      port_q  <= port_d;
    end
  end

endmodule

// File: rtl/irc_queue.sv
// ----------------------------------------------------------------------------
// IPv4 receive classifier summary queue
// Short first-in first-out buffer of packet summaries between front and back.
// ----------------------------------------------------------------------------
module irc_queue import irc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  irc_summary_t push_data_i,
  input  logic         pop_i,
  output logic         empty_o,
  output irc_qctl_t    ctl_o,
  output irc_summary_t head_o
);

  localparam logic [QPTR_W:0] CountFull = (QPTR_W + 1)'(QUEUE_DEPTH);

  irc_summary_t        entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, wptr_d;
  logic [QPTR_W-1:0]   rptr_q, rptr_d;
  logic [QPTR_W:0]     count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) wptr_d = wptr_q + 1'b1;
    if (pop_i)  rptr_d = rptr_q + 1'b1;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

  assign empty_o    = (count_q == '0);
  assign ctl_o.full = (count_q == CountFull);
  assign ctl_o.push = push_i;
  assign head_o     = entries_q[rptr_q];

endmodule

// File: rtl/irc_back.sv
// ----------------------------------------------------------------------------
// IPv4 receive classifier back end
// Judges the packet summary at the head of the queue, updates the counters
// and holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module irc_back import irc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         head_valid_i,
  input  irc_summary_t head_i,
  input  irc_cfg_t     cfg_i,
  output logic         pop_o,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output logic [3:0]   verdict_o,
  output logic [5:0]   header_bytes_o,
  output logic [15:0]  payload_bytes_o,
  output logic [31:0]  source_address_o,
  output logic [31:0]  destination_address_o,
  output logic [7:0]   time_to_live_o,
  output logic [31:0]  received_total_o,
  output logic [31:0]  policy_drops_total_o
);

  logic         valid_q, valid_d;
  irc_verdict_e verdict_q, verdict_d;
  logic [5:0]   hdr_q;
  logic [15:0]  payload_q, payload_d;
  logic [31:0]  src_q;
  logic [31:0]  dst_q;
  logic [7:0]   ttl_q;
  logic [31:0]  rcv_q, rcv_d;
  logic [31:0]  drops_q, drops_d;

  logic [3:0]  ihl;
  logic [5:0]  hl;
  logic [16:0] hl17;
  logic [16:0] len17;
  logic [16:0] total17;
  logic        is_udp;
  logic        is_tcp;
  logic        policy_ok;
  logic        own_set;
  logic        addressed;
  logic        dst_common;

  always_comb begin
    ihl     = head_i.ver_len[3:0];
    hl      = {ihl, 2'b00};
    hl17    = {11'b0, hl};
    len17   = {1'b0, head_i.len};
    total17 = {1'b0, head_i.total_len};
    is_udp  = (head_i.proto == PROTO_UDP);
    is_tcp  = (head_i.proto == PROTO_TCP);

    policy_ok = head_i.auth || (head_i.dst == cfg_i.own_first);
    if (!policy_ok) begin
      if (is_udp) begin
        policy_ok = (len17 >= hl17 + UDP_HDR_BYTES) &&
                    (head_i.port == PORT_BOOTPS || head_i.port == PORT_BOOTPC ||
                     head_i.port == PORT_DNS);
      end else if (is_tcp) begin
        policy_ok = (len17 >= hl17 + TCP_HDR_BYTES) &&
                    (head_i.port == PORT_HTTP || head_i.port == PORT_SSH);
      end
    end

    dst_common = (head_i.dst == ADDR_BROADCAST) || (head_i.dst == ADDR_LOOPBACK);
    own_set    = (cfg_i.own_first != '0) || (cfg_i.own_second != '0);
    if (own_set) begin
      addressed = dst_common || (head_i.dst == cfg_i.own_first) ||
                  (head_i.dst == cfg_i.own_second);
    end else begin
      // Unconfigured: let address negotiation traffic through.
      addressed = dst_common || (head_i.dst == ADDR_ANY) ||
                  (is_udp && (total17 >= hl17 + UDP_HDR_BYTES) &&
                   (head_i.port == PORT_BOOTPC)) ||
                  ((cfg_i.offered != '0) && (head_i.dst == cfg_i.offered));
    end

    payload_d = '0;
    priority if (head_i.len < HDR_MIN_BYTES) begin
      verdict_d = VERDICT_SHORT;
    end else if (head_i.ver_len[7:4] != IP_VERSION4) begin
      verdict_d = VERDICT_VERSION;
    end else if ((ihl < IHL_MIN) || (len17 < hl17)) begin
      verdict_d = VERDICT_HEADER;
    end else if (head_i.hdr_sum != SUM_ALL_ONES) begin
      verdict_d = VERDICT_CHECKSUM;
    end else if (!policy_ok) begin
      verdict_d = VERDICT_POLICY;
    end else if (head_i.len < head_i.total_len) begin
      verdict_d = VERDICT_TRUNCATED;
    end else if (total17 < hl17) begin
      verdict_d = VERDICT_HEADER;
    end else if (!addressed) begin
      verdict_d = VERDICT_NOTOURS;
    end else if (head_i.proto == PROTO_ICMP) begin
      verdict_d = VERDICT_ICMP;
      payload_d = head_i.total_len - {10'b0, hl};
    end else if (is_udp) begin
      verdict_d = VERDICT_UDP;
      payload_d = head_i.total_len - {10'b0, hl};
    end else if (is_tcp) begin
      verdict_d = VERDICT_TCP;
      payload_d = head_i.total_len - {10'b0, hl};
    end else begin
      verdict_d = VERDICT_PROTOCOL;
    end
  end

  // The output register takes a new summary whenever it is empty or drained.
  assign pop_o = head_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q;
    rcv_d   = rcv_q;
    drops_d = drops_q;
    if (!valid_q || !out_stall_i) valid_d = head_valid_i;
    if (pop_o) begin
      rcv_d = rcv_q + 32'd1;
      if (verdict_d == VERDICT_POLICY) drops_d = drops_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rcv_q   <= '0;
      drops_q <= '0;
    end else begin
      valid_q <= valid_d;
      rcv_q   <= rcv_d;
      drops_q <= drops_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict_d;
      hdr_q     <= hl;
      payload_q <= payload_d;
      src_q     <= head_i.src;
      dst_q     <= head_i.dst;
      ttl_q     <= head_i.ttl;
    end
  end

  assign out_valid_o           = valid_q;
  assign verdict_o             = verdict_q;
  assign header_bytes_o        = hdr_q;
  assign payload_bytes_o       = payload_q;
  assign source_address_o      = src_q;
  assign destination_address_o = dst_q;
  assign time_to_live_o        = ttl_q;
  // The counters only move on a load, so they belong to the held result.
  assign received_total_o      = rcv_q;
  assign policy_drops_total_o  = drops_q;

endmodule

// File: rtl/ipv4_receive_classifier.sv
// ----------------------------------------------------------------------------
// IPv4 receive classifier
// Takes one 16-bit packet word per cycle; no word is ever held back by work.
// After its last word's transaction, a packet's summary passes through the
// summary queue and then the output register before its result is valid.
// Up to four results can wait in the queue; the input stalls only when full.
// Asynchronous active-low reset clears control state, counters and config.
// ----------------------------------------------------------------------------
//
// Structure:
//   The front end (irc_front) tracks the byte offset within the packet and
//   captures version/length, total length, time to live, protocol, source and
//   destination address and the transport port found two bytes past the end
//   of the header. It folds every header word into a ones' complement sum.
//   When the last word is taken it pushes a summary of the whole packet into
//   a four-entry queue (irc_queue) and clears its per-packet state, so the
//   next packet's first word can follow in the very next cycle.
//
//   The back end (irc_back) judges the summary at the head of the queue
//   combinationally: length, version, header length, checksum, access policy,
//   truncation, destination filter and protocol are checked in that order.
//   The verdict, the captured fields and the two wrapping counters are held
//   in an output register until the downstream side takes the transaction.
//
// Configuration writes land in three address registers. They are expected
// only while no packet is in flight, so the back end reads them directly.
module ipv4_receive_classifier import irc_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Packet word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] packet_word_i,
  input  logic        last_word_i,
  input  logic        odd_tail_i,
  input  logic        source_authenticated_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  verdict_o,
  output logic [5:0]  header_bytes_o,
  output logic [15:0] payload_bytes_o,
  output logic [31:0] source_address_o,
  output logic [31:0] destination_address_o,
  output logic [7:0]  time_to_live_o,
  output logic [31:0] received_total_o,
  output logic [31:0] policy_drops_total_o,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  irc_cfg_t     cfg_q, cfg_d;
  irc_summary_t summary;
  irc_summary_t head;
  irc_qctl_t    qctl;
  logic         push;
  logic         pop;
  logic         empty;

  // Configuration writes are always taken; an index past the last register
  // completes its transaction but changes nothing.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_OWN_FIRST:  cfg_d.own_first  = cfg_data_i;
        CFG_OWN_SECOND: cfg_d.own_second = cfg_data_i;
        CFG_OFFERED:    cfg_d.offered    = cfg_data_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The input stalls only while the summary queue is full.
  assign in_stall_o = qctl.full;

  irc_front #(
    .MaxPacketBytes(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .packet_word_i         (packet_word_i),
    .last_word_i           (last_word_i),
    .odd_tail_i            (odd_tail_i),
    .source_authenticated_i(source_authenticated_i),
    .push_o                (push),
    .summary_o             (summary)
  );

  irc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(summary),
    .pop_i      (pop),
    .empty_o    (empty),
    .ctl_o      (qctl),
    .head_o     (head)
  );

  irc_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .head_valid_i         (!empty),
    .head_i               (head),
    .cfg_i                (cfg_q),
    .pop_o                (pop),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .verdict_o            (verdict_o),
    .header_bytes_o       (header_bytes_o),
    .payload_bytes_o      (payload_bytes_o),
    .source_address_o     (source_address_o),
    .destination_address_o(destination_address_o),
    .time_to_live_o       (time_to_live_o),
    .received_total_o     (received_total_o),
    .policy_drops_total_o (policy_drops_total_o)
  );

endmodule

// File: rtl/irc_checker.sv
// ----------------------------------------------------------------------------
// IPv4 receive classifier checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irc_checker import irc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  verdict_o,
  input logic [5:0]  header_bytes_o,
  input logic [15:0] payload_bytes_o,
  input logic [31:0] received_total_o,
  input logic [31:0] policy_drops_total_o
);

  `IRC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o), "stalled result changed")
  `IRC_ASSERT(a_rcv_step, out_valid_o && $past(out_valid_o && !out_stall_i) |-> received_total_o == $past(received_total_o) + 32'd1, "received count did not advance by one")
  `IRC_ASSERT(a_drop_step, out_valid_o && $past(out_valid_o && !out_stall_i) |-> policy_drops_total_o == $past(policy_drops_total_o) + ((verdict_o == VERDICT_POLICY) ? 32'd1 : 32'd0), "policy drop count out of step with verdict")
  `IRC_ASSERT_NEVER(a_drop_payload, out_valid_o && (verdict_o > VERDICT_TCP) && (payload_bytes_o != 16'd0), "dropped packet carries a payload length")
  `IRC_ASSERT_NEVER(a_deliver_hdr, out_valid_o && (verdict_o <= VERDICT_TCP) && (header_bytes_o < 6'd20), "delivered packet with short header")

endmodule

bind ipv4_receive_classifier irc_checker u_irc_checker (.*);

// File: verif/tb_ipv4_receive_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 receive classifier testbench
// Streams IPv4 packets, broken packets and random noise into the classifier
// word by word, predicts each packet verdict in a local model and checks every
// result field. Runs several address settings with different idle patterns.
// ----------------------------------------------------------------------------
module tb_ipv4_receive_classifier;
  import irc_pkg::*;

  localparam int unsigned MAX_BYTES = 65535;
  // Words of random traffic queued per phase.
  localparam int unsigned PHASE_WORDS = 180;
  // Cycles allowed after the last result before a setting may change.
  localparam int unsigned SETTLE_CYCLES = 8;

  // One transaction on the packet word channel.
  typedef struct {
    logic [15:0] word;
    logic        last;
    logic        odd;
    logic        auth;
  } word_item_t;

  // Everything the monitor compares for one finished packet.
  typedef struct {
    irc_verdict_e verdict;
    logic [5:0]   hdr_bytes;
    logic [15:0]  payload;
    logic [31:0]  src;
    logic [31:0]  dst;
    logic [7:0]   ttl;
    logic [31:0]  rx_total;
    logic [31:0]  policy_total;
  } packet_verdict_t;

  // Description of a packet to be built; keep of zero sends every byte.
  typedef struct {
    logic [3:0]  version;
    logic [3:0]  ihl;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] port;
    int unsigned body;
    logic [15:0] total;
    int unsigned pad;
    int unsigned keep;
    logic        bad_sum;
    logic        auth;
  } ip_shape_t;

  // Clock, reset and every block input start at known values.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [15:0] packet_word = '0;
  logic        last_word = 1'b0;
  logic        odd_tail = 1'b0;
  logic        src_auth = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic        in_stall;
  logic        out_valid;
  logic [3:0]  verdict;
  logic [5:0]  header_bytes;
  logic [15:0] payload_bytes;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [7:0]  time_to_live;
  logic [31:0] received_total;
  logic [31:0] policy_drops_total;
  logic        cfg_ready;

  // Words waiting for the driver and verdicts waiting for the monitor.
  word_item_t      word_queue[$];
  packet_verdict_t pending_verdicts[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned results_checked = 0;
  int unsigned words_planned = 0;

  // Local copy of the address registers.
  logic [31:0] own_first = '0;
  logic [31:0] own_second = '0;
  logic [31:0] offered = '0;

  // Local copy of the per-packet capture state and the two counters.
  logic [15:0] pkt_bytes = '0;
  logic [15:0] hdr_sum = '0;
  logic [7:0]  ver_len = '0;
  logic [15:0] total_len = '0;
  logic [7:0]  ttl_byte = '0;
  logic [7:0]  proto_byte = '0;
  logic [31:0] src_addr = '0;
  logic [31:0] dst_addr = '0;
  logic [15:0] dport = '0;
  logic [31:0] rx_total = '0;
  logic [31:0] policy_total = '0;

  ipv4_receive_classifier #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) u_top (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .packet_word_i         (packet_word),
    .last_word_i           (last_word),
    .odd_tail_i            (odd_tail),
    .source_authenticated_i(src_auth),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .verdict_o             (verdict),
    .header_bytes_o        (header_bytes),
    .payload_bytes_o       (payload_bytes),
    .source_address_o      (source_address),
    .destination_address_o (destination_address),
    .time_to_live_o        (time_to_live),
    .received_total_o      (received_total),
    .policy_drops_total_o  (policy_drops_total),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Ones' complement addition with the end-around carry folded back in.
  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Access policy: authenticated sources, primary address, listed UDP/TCP ports.
  function automatic bit admits(input int unsigned len, input int unsigned hl,
                                input logic auth);
    if (auth) return 1'b1;
    if (dst_addr == own_first) return 1'b1;
    if (proto_byte == PROTO_UDP)
      return (len >= hl + UDP_HDR_BYTES) &&
             (dport == PORT_BOOTPS || dport == PORT_BOOTPC || dport == PORT_DNS);
    if (proto_byte == PROTO_TCP)
      return (len >= hl + TCP_HDR_BYTES) && (dport == PORT_HTTP || dport == PORT_SSH);
    return 1'b0;
  endfunction

  // Destination filter. Without a configured address the interface is still
  // being brought up, so the client bootstrap port and the offer get through.
  function automatic bit addressed_here(input int unsigned len, input int unsigned hl);
    if (own_first != ADDR_ANY || own_second != ADDR_ANY)
      return dst_addr == own_first || dst_addr == own_second ||
             dst_addr == ADDR_BROADCAST || dst_addr == ADDR_LOOPBACK;
    if (proto_byte == PROTO_UDP && len >= hl + UDP_HDR_BYTES && dport == PORT_BOOTPC)
      return 1'b1;
    return dst_addr == ADDR_BROADCAST || dst_addr == ADDR_LOOPBACK ||
           dst_addr == ADDR_ANY || (offered != ADDR_ANY && dst_addr == offered);
  endfunction

  // Runs the checks in the block's priority order. A policy drop bumps its
  // counter; only delivered packets report a payload length.
  task automatic judge_packet(input int unsigned len, input logic auth,
                              output irc_verdict_e v, output logic [15:0] payload);
    int unsigned hl;
    hl = 4 * ver_len[3:0];
    payload = '0;
    if (len < HDR_MIN_BYTES) v = VERDICT_SHORT;
    else if (ver_len[7:4] != IP_VERSION4) v = VERDICT_VERSION;
    else if (ver_len[3:0] < IHL_MIN || len < hl) v = VERDICT_HEADER;
    else if (hdr_sum != SUM_ALL_ONES) v = VERDICT_CHECKSUM;
    else if (!admits(len, hl, auth)) begin
      policy_total = policy_total + 1;
      v = VERDICT_POLICY;
    end else if (len < total_len) v = VERDICT_TRUNCATED;
    else if (total_len < hl) v = VERDICT_HEADER;
    else if (!addressed_here(total_len, hl)) v = VERDICT_NOTOURS;
    else if (proto_byte == PROTO_ICMP || proto_byte == PROTO_UDP ||
             proto_byte == PROTO_TCP) begin
      payload = total_len - hl;
      if (proto_byte == PROTO_ICMP) v = VERDICT_ICMP;
      else if (proto_byte == PROTO_UDP) v = VERDICT_UDP;
      else v = VERDICT_TCP;
    end else v = VERDICT_PROTOCOL;
  endtask

  // Folds one accepted word into the local state. The last word of a packet
  // produces one verdict and clears everything but the counters.
  task automatic absorb_word(input logic [15:0] word_in, input logic last,
                             input logic odd_in, input logic auth);
    logic [15:0]     w;
    logic            odd;
    int unsigned     off;
    int unsigned     hl;
    int unsigned     n;
    packet_verdict_t rec;
    odd = last && odd_in;
    w = odd ? {word_in[15:8], 8'h00} : word_in;
    off = pkt_bytes;
    // Past the byte limit the count sticks and nothing more is captured.
    if (off < MAX_BYTES) begin
      if (off == OFF_VER_LEN) ver_len = w[15:8];
      hl = 4 * ver_len[3:0];
      if (off < hl) hdr_sum = ones_add(hdr_sum, w);
      if (off == OFF_TOTAL) total_len = w;
      if (off == OFF_TTL) begin
        ttl_byte = w[15:8];
        proto_byte = w[7:0];
      end
      if (off == OFF_SRC_HI) src_addr[31:16] = w;
      if (off == OFF_SRC_LO) src_addr[15:0] = w;
      if (off == OFF_DST_HI) dst_addr[31:16] = w;
      if (off == OFF_DST_LO) dst_addr[15:0] = w;
      if (off == hl + 2) dport = w;
      n = off + (odd ? 1 : 2);
      if (n > MAX_BYTES) n = MAX_BYTES;
      pkt_bytes = n;
    end
    if (last) begin
      rx_total = rx_total + 1;
      judge_packet(pkt_bytes, auth, rec.verdict, rec.payload);
      rec.hdr_bytes = {ver_len[3:0], 2'b00};
      rec.src = src_addr;
      rec.dst = dst_addr;
      rec.ttl = ttl_byte;
      rec.rx_total = rx_total;
      rec.policy_total = policy_total;
      pending_verdicts.push_back(rec);
      pkt_bytes = '0;
      hdr_sum = '0;
      ver_len = '0;
      total_len = '0;
      ttl_byte = '0;
      proto_byte = '0;
      src_addr = '0;
      dst_addr = '0;
      dport = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued words, idling at random. A new word is loaded
  // only once the current one has completed its transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    word_item_t next_item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_word(packet_word, last_word, odd_tail, src_auth);
      end
      if (!in_valid || !in_stall) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = word_queue.pop_front();
          in_valid <= 1'b1;
          packet_word <= next_item.word;
          last_word <= next_item.last;
          odd_tail <= next_item.odd;
          src_auth <= next_item.auth;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic note_failure(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      note_failure($sformatf("packet %0d %s: got 0x%0h, expected 0x%0h",
                             results_checked, name, got, want));
  endtask

  task automatic check_result();
    packet_verdict_t want;
    if (pending_verdicts.size() == 0) begin
      note_failure("result transaction with no packet outstanding");
    end else begin
      want = pending_verdicts.pop_front();
      compare_field("verdict", 32'(verdict), 32'(want.verdict));
      compare_field("header_bytes", 32'(header_bytes), 32'(want.hdr_bytes));
      compare_field("payload_bytes", 32'(payload_bytes), 32'(want.payload));
      compare_field("source_address", source_address, want.src);
      compare_field("destination_address", destination_address, want.dst);
      compare_field("time_to_live", 32'(time_to_live), 32'(want.ttl));
      compare_field("received_total", received_total, want.rx_total);
      compare_field("policy_drops_total", policy_drops_total, want.policy_total);
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return $urandom_range(255);
  endfunction

  task automatic push_word(input logic [15:0] w, input logic last, input logic odd,
                           input logic auth);
    word_item_t it;
    it.word = w;
    it.last = last;
    it.odd = odd;
    it.auth = auth;
    word_queue.push_back(it);
    words_planned++;
  endtask

  // A well-formed header with a 20-byte length and the given transport fields.
  function automatic ip_shape_t base_shape(input logic [7:0] proto, input logic [31:0] dst,
                                           input logic [15:0] port, input int unsigned body,
                                           input logic auth);
    ip_shape_t s;
    s.version = IP_VERSION4;
    s.ihl = IHL_MIN;
    s.ttl = rand_byte();
    s.proto = proto;
    s.src = $urandom;
    s.dst = dst;
    s.port = port;
    s.body = body;
    s.total = HDR_MIN_BYTES + body;
    s.pad = 0;
    s.keep = 0;
    s.bad_sum = 1'b0;
    s.auth = auth;
    return s;
  endfunction

  // Builds the packet bytes with a valid checksum (unless told to spoil it),
  // then splits them into words. The odd tail's lower byte is random garbage
  // and the tail and authentication bits are random on all but the last word.
  task automatic emit_packet(input ip_shape_t s);
    logic [7:0]  b[$];
    logic [15:0] sum;
    logic [15:0] ck;
    int          hl;
    int          i;
    logic        last;
    hl = 4 * s.ihl;
    b.push_back({s.version, s.ihl});
    b.push_back(rand_byte());
    b.push_back(s.total[15:8]);
    b.push_back(s.total[7:0]);
    for (i = 0; i < 4; i++) b.push_back(rand_byte());
    b.push_back(s.ttl);
    b.push_back(s.proto);
    b.push_back(8'h00);
    b.push_back(8'h00);
    for (i = 3; i >= 0; i--) b.push_back(s.src[8*i +: 8]);
    for (i = 3; i >= 0; i--) b.push_back(s.dst[8*i +: 8]);
    while (b.size() < hl) b.push_back(rand_byte());
    for (i = 0; i < s.body; i++) begin
      if (i == 2) b.push_back(s.port[15:8]);
      else if (i == 3) b.push_back(s.port[7:0]);
      else b.push_back(rand_byte());
    end
    for (i = 0; i < s.pad; i++) b.push_back(rand_byte());
    sum = '0;
    for (i = 0; i + 1 < hl && i + 1 < b.size(); i += 2) sum = ones_add(sum, {b[i], b[i+1]});
    ck = ~sum;
    if (s.bad_sum) ck = ck ^ 16'($urandom_range(16'hFFFE, 1));
    b[10] = ck[15:8];
    b[11] = ck[7:0];
    if (s.keep != 0) begin
      while (b.size() > s.keep) void'(b.pop_back());
    end
    for (i = 0; i < b.size(); i += 2) begin
      last = (i + 2 >= b.size());
      push_word({b[i], (i + 1 < b.size()) ? b[i+1] : rand_byte()}, last,
                last ? (i + 1 == b.size()) : 1'($urandom_range(1)),
                last ? s.auth : 1'($urandom_range(1)));
    end
  endtask

  // A burst of arbitrary words; the burst always ends on a last word so the
  // block is between packets when the burst is done.
  task automatic emit_noise();
    int unsigned n;
    int unsigned i;
    n = $urandom_range(14, 1);
    for (i = 0; i < n; i++)
      push_word(16'($urandom), (i == n - 1) || ($urandom_range(7) == 0),
                1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  function automatic logic [31:0] pick_destination();
    case ($urandom_range(7))
      0: return own_first;
      1: return own_second;
      2: return offered;
      3: return ADDR_BROADCAST;
      4: return ADDR_LOOPBACK;
      5: return ADDR_ANY;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(6))
      0: return PORT_BOOTPS;
      1: return PORT_BOOTPC;
      2: return PORT_DNS;
      3: return PORT_HTTP;
      4: return PORT_SSH;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_protocol();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return PROTO_ICMP;
    if (r < 5) return PROTO_UDP;
    if (r < 8) return PROTO_TCP;
    return rand_byte();
  endfunction

  // Mostly well-formed packets with random content, so the policy, filter and
  // protocol stages see plenty of traffic; a minority is spoiled one way or
  // another, and about one burst in ten is pure noise.
  task automatic queue_random_traffic(input int unsigned word_budget);
    ip_shape_t   s;
    int unsigned start;
    int unsigned r;
    int unsigned hl;
    start = words_planned;
    while (words_planned - start < word_budget) begin
      if ($urandom_range(9) == 0) begin
        emit_noise();
      end else begin
        r = $urandom_range(99);
        s = base_shape(pick_protocol(), pick_destination(), pick_port(),
                       (r < 50) ? $urandom_range(24) : $urandom_range(48),
                       $urandom_range(9) < 3);
        r = $urandom_range(99);
        if (r < 3) s.ihl = $urandom_range(4);
        else if (r >= 80) s.ihl = $urandom_range(15, 5);
        hl = 4 * s.ihl;
        s.total = hl + s.body;
        if ($urandom_range(99) < 10) s.total = $urandom_range(hl + s.body + 8);
        if ($urandom_range(99) < 4) s.version = $urandom_range(15);
        if ($urandom_range(99) < 5) s.bad_sum = 1'b1;
        if ($urandom_range(99) < 20) s.pad = $urandom_range(5, 1);
        if ($urandom_range(99) < 5) s.keep = $urandom_range(hl + s.body + s.pad, 1);
        if ($urandom_range(9) == 0) s.ttl = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        emit_packet(s);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  task automatic write_register(input irc_cfg_index_e idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OWN_FIRST:  own_first = value;
      CFG_OWN_SECOND: own_second = value;
      CFG_OFFERED:    offered = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Holds the sender off until every word is taken and every verdict is back,
  // then lets the back end settle before anything changes.
  task automatic wait_drained();
    do @(negedge clk); while (word_queue.size() != 0 || in_valid ||
                              pending_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_addresses(input logic [31:0] first, input logic [31:0] second,
                               input logic [31:0] offer);
    write_register(CFG_OWN_FIRST, first);
    write_register(CFG_OWN_SECOND, second);
    write_register(CFG_OFFERED, offer);
  endtask

  task automatic run_phase(input logic [31:0] first, input logic [31:0] second,
                           input logic [31:0] offer, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    set_addresses(first, second, offer);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_traffic(PHASE_WORDS);
    wait_drained();
  endtask

  // Handcrafted packets for the bring-up setting (no addresses configured).
  task automatic queue_directed();
    ip_shape_t s;
    // Shortest possible packets: one word, and nineteen bytes with an odd tail.
    push_word(16'hFFFF, 1'b1, 1'b0, 1'b1);
    push_word(16'h0000, 1'b1, 1'b1, 1'b0);
    s = base_shape(PROTO_UDP, ADDR_BROADCAST, PORT_BOOTPC, 8, 1'b1);
    s.keep = 19;
    emit_packet(s);
    // Wrong version, header length nibble below five, header cut off early.
    s = base_shape(PROTO_UDP, ADDR_BROADCAST, PORT_BOOTPC, 8, 1'b1);
    s.version = 4'd6;
    emit_packet(s);
    s = base_shape(PROTO_UDP, ADDR_BROADCAST, PORT_BOOTPC, 8, 1'b1);
    s.ihl = 4'd4;
    emit_packet(s);
    s = base_shape(PROTO_TCP, ADDR_BROADCAST, PORT_HTTP, 0, 1'b1);
    s.ihl = 4'd15;
    s.total = 60;
    s.keep = 40;
    emit_packet(s);
    // Spoiled checksum.
    s = base_shape(PROTO_ICMP, ADDR_BROADCAST, PORT_DNS, 8, 1'b1);
    s.bad_sum = 1'b1;
    emit_packet(s);
    // Policy drops: UDP to a closed port, TCP too short to hold its header.
    emit_packet(base_shape(PROTO_UDP, 32'h0A00_0002, 16'd1234, 12, 1'b0));
    emit_packet(base_shape(PROTO_TCP, 32'h0A00_0002, PORT_HTTP, 19, 1'b0));
    // Client bootstrap port to a foreign address passes policy and filter.
    emit_packet(base_shape(PROTO_UDP, 32'hC0A8_0105, PORT_BOOTPC, 8, 1'b0));
    // Total length beyond the received bytes, then below the header length.
    s = base_shape(PROTO_UDP, ADDR_BROADCAST, PORT_DNS, 10, 1'b1);
    s.total = HDR_MIN_BYTES + 16;
    emit_packet(s);
    s = base_shape(PROTO_UDP, ADDR_BROADCAST, PORT_DNS, 10, 1'b1);
    s.total = 12;
    emit_packet(s);
    // Not addressed here, and an unknown protocol.
    emit_packet(base_shape(PROTO_ICMP, 32'h0A00_0002, PORT_DNS, 8, 1'b1));
    emit_packet(base_shape(8'd2, ADDR_BROADCAST, PORT_DNS, 8, 1'b1));
    // Deliveries: ICMP to loopback, ICMP to the unset primary address with no
    // authentication, TCP to the wildcard address with a zero TTL.
    emit_packet(base_shape(PROTO_ICMP, ADDR_LOOPBACK, PORT_DNS, 0, 1'b1));
    emit_packet(base_shape(PROTO_ICMP, ADDR_ANY, 16'hFFFF, 4, 1'b0));
    s = base_shape(PROTO_TCP, ADDR_ANY, PORT_SSH, 20, 1'b0);
    s.ttl = 8'h00;
    emit_packet(s);
    // Trailing link padding is trimmed; odd payload ends in an odd tail.
    s = base_shape(PROTO_UDP, ADDR_BROADCAST, PORT_DNS, 12, 1'b0);
    s.pad = 5;
    s.ttl = 8'hFF;
    emit_packet(s);
    emit_packet(base_shape(PROTO_UDP, ADDR_BROADCAST, PORT_BOOTPS, 9, 1'b0));
    // Full-size header with options.
    s = base_shape(PROTO_TCP, ADDR_BROADCAST, PORT_HTTP, 20, 1'b1);
    s.ihl = 4'd15;
    s.total = 80;
    emit_packet(s);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Bring-up setting with no idling: directed packets, then random traffic.
    set_addresses(ADDR_ANY, ADDR_ANY, ADDR_ANY);
    queue_directed();
    wait_drained();
    queue_random_traffic(PHASE_WORDS);
    wait_drained();

    // Both interfaces configured while the sender idles often.
    run_phase($urandom, $urandom, ADDR_ANY, 68, 0);
    // Negotiation in progress while the receiver stalls often.
    run_phase(ADDR_ANY, ADDR_ANY, $urandom_range(32'hFFFF_FFFF, 1), 0, 68);
    // All-ones extremes with both sides idling now and then.
    run_phase(32'hFFFF_FFFF, ADDR_ANY, 32'hFFFF_FFFF, 24, 24);
    // Only the second interface configured, no idling.
    run_phase(ADDR_ANY, 32'hFFFF_FFFF, ADDR_ANY, 0, 0);

    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("** ipv4_receive_classifier: PASSED **");
    end else begin
      $display("** ipv4_receive_classifier: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run under the heaviest stalls.
  initial begin
    #20_000_000;
    $display("[%0t] ERROR: timeout with %0d words and %0d verdicts outstanding",
             $realtime, word_queue.size(), pending_verdicts.size());
    $display("** ipv4_receive_classifier: FAILED **");
    $finish;
  end

endmodule

// File: ipv4_receive_classifier.f
+incdir+rtl
rtl/irc_pkg.sv
rtl/irc_front.sv
rtl/irc_queue.sv
rtl/irc_back.sv
rtl/ipv4_receive_classifier.sv
rtl/irc_checker.sv
verif/tb_ipv4_receive_classifier.sv
